/* design/vst_pkg.sv */
package vst_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int SCALE_WIDTH   = 24;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int COEF_WIDTH    = 32;
  // scaled and translated vector component, headroom over the coordinate width
  localparam int VEC_WIDTH     = COORD_WIDTH + 10;
  localparam int LO_WIDTH      = 24;
  localparam int HI_WIDTH      = VEC_WIDTH - LO_WIDTH;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCALE    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Z = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_X  = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_Y  = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_Z  = 3'd6;

  localparam logic signed [COEF_WIDTH-1:0]  ONE_Q30   = 32'sh4000_0000;
  localparam logic signed [SCALE_WIDTH-1:0] SCALE_ONE = 24'sh01_0000;

  typedef logic signed [VEC_WIDTH-1:0] vcomp_t;
  typedef struct packed {
    vcomp_t x;
    vcomp_t y;
    vcomp_t z;
  } vec_t;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef coef_t [8:0] mat_t;

endpackage

/* design/vst_queue.sv */
module vst_queue import vst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  vec_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output vec_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  vec_t           q_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;
  logic [PW:0]    count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full     = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = q_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/vst_coef.sv */
module vst_coef import vst_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [ANGLE_WIDTH-1:0]    cfg_angle,
  output logic                      busy,
  output mat_t                      mat
);

  localparam int CW    = 34;
  localparam logic signed [CW-1:0] GAIN = 34'sd652032874;
  localparam logic [4:0]  LAST_ITER = 5'd29;
  localparam logic [3:0]  LAST_STEP = 4'd13;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ITER  = 6'b000100,
    ST_STORE = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_ACC   = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    OP_C0, OP_S0, OP_C1, OP_S1, OP_C2, OP_S2, OP_TA, OP_TB
  } opnd_t;

  typedef enum logic [2:0] {
    ACT_TA, ACT_TB, ACT_SET, ACT_NEG, ACT_ACC, ACT_ADD, ACT_SUB
  } act_t;

  typedef struct packed {
    opnd_t      a;
    opnd_t      b;
    act_t       act;
    logic [3:0] dest;
  } uop_t;

  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10680862;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // product schedule: ta = s0*s1, tb = c0*s1, then twelve products for eight of the nine matrix entries
  function automatic uop_t uop_lut(input logic [3:0] step);
    uop_t u;
    case (step)
      4'd0:  u = '{a: OP_S0, b: OP_S1, act: ACT_TA,  dest: 4'd0};
      4'd1:  u = '{a: OP_C0, b: OP_S1, act: ACT_TB,  dest: 4'd0};
      4'd2:  u = '{a: OP_C1, b: OP_C2, act: ACT_SET, dest: 4'd0};
      4'd3:  u = '{a: OP_C0, b: OP_S2, act: ACT_ACC, dest: 4'd1};
      4'd4:  u = '{a: OP_TA, b: OP_C2, act: ACT_ADD, dest: 4'd1};
      4'd5:  u = '{a: OP_S0, b: OP_S2, act: ACT_ACC, dest: 4'd2};
      4'd6:  u = '{a: OP_TB, b: OP_C2, act: ACT_SUB, dest: 4'd2};
      4'd7:  u = '{a: OP_C1, b: OP_S2, act: ACT_NEG, dest: 4'd3};
      4'd8:  u = '{a: OP_C0, b: OP_C2, act: ACT_ACC, dest: 4'd4};
      4'd9:  u = '{a: OP_TA, b: OP_S2, act: ACT_SUB, dest: 4'd4};
      4'd10: u = '{a: OP_S0, b: OP_C2, act: ACT_ACC, dest: 4'd5};
      4'd11: u = '{a: OP_TB, b: OP_S2, act: ACT_ADD, dest: 4'd5};
      4'd12: u = '{a: OP_S0, b: OP_C1, act: ACT_NEG, dest: 4'd7};
      4'd13: u = '{a: OP_C0, b: OP_C1, act: ACT_SET, dest: 4'd8};
      default: u = '{a: OP_C0, b: OP_C0, act: ACT_ACC, dest: 4'd0};
    endcase
    return u;
  endfunction

  function automatic coef_t clamp_q30(input logic signed [39:0] v);
    coef_t r;
    if (v > 40'sd1073741824) begin
      r = ONE_Q30;
    end else if (v < -40'sd1073741824) begin
      r = -ONE_Q30;
    end else begin
      r = v[COEF_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic coef_t sel_opnd(input opnd_t o, input coef_t c0, input coef_t s0,
                                     input coef_t c1, input coef_t s1, input coef_t c2,
                                     input coef_t s2, input coef_t ta, input coef_t tb);
    coef_t r;
    case (o)
      OP_C0:   r = c0;
      OP_S0:   r = s0;
      OP_C1:   r = c1;
      OP_S1:   r = s1;
      OP_C2:   r = c2;
      OP_S2:   r = s2;
      OP_TA:   r = ta;
      OP_TB:   r = tb;
      default: r = c0;
    endcase
    return r;
  endfunction

  state_t                  state_r;
  state_t                  state_nxt;
  logic [1:0]              axis_r;
  logic [4:0]              iter_r;
  logic [3:0]              step_r;
  logic [1:0]              quad_r;
  logic signed [CW-1:0]    cx_r;
  logic signed [CW-1:0]    cy_r;
  logic signed [CW-1:0]    cz_r;
  logic [ANGLE_WIDTH-1:0]  ang_r [3];
  coef_t                   cos_r [3];
  coef_t                   sin_r [3];
  coef_t                   ta_r;
  coef_t                   tb_r;
  logic signed [CW-1:0]    acc_r;
  logic signed [63:0]      prod_r;
  mat_t                    mat_r;

  logic [31:0]             phase;
  logic [31:0]             qsum;
  logic [1:0]              quad;
  logic [31:0]             resid_u;
  logic signed [CW-1:0]    dx;
  logic signed [CW-1:0]    dy;
  logic signed [CW-1:0]    atan_v;
  coef_t                   xc;
  coef_t                   yc;
  coef_t                   cos_v;
  coef_t                   sin_v;
  uop_t                    uop;
  coef_t                   opa;
  coef_t                   opb;
  logic signed [63:0]      prod_nxt;
  logic signed [63:0]      prod_rnd;
  logic signed [CW-1:0]    rnd;
  logic                    angle_wr;

  assign busy = (state_r != ST_IDLE);
  assign mat  = mat_r;

  assign angle_wr = cfg_we && ((cfg_index == REG_ANGLE_X) || (cfg_index == REG_ANGLE_Y) ||
                               (cfg_index == REG_ANGLE_Z));

  always_comb begin
    phase   = {ang_r[axis_r], {(32-ANGLE_WIDTH){1'b0}}};
    qsum    = phase + 32'h2000_0000;
    quad    = qsum[31:30];
    resid_u = phase - {quad, 30'd0};
    dx      = cy_r >>> iter_r;
    dy      = cx_r >>> iter_r;
    atan_v  = atan_lut(iter_r);
    xc      = clamp_q30(40'(cx_r));
    yc      = clamp_q30(40'(cy_r));
    case (quad_r)
      2'd0: begin
        cos_v = xc;
        sin_v = yc;
      end
      2'd1: begin
        cos_v = -yc;
        sin_v = xc;
      end
      2'd2: begin
        cos_v = -xc;
        sin_v = -yc;
      end
      default: begin
        cos_v = yc;
        sin_v = -xc;
      end
    endcase
    uop      = uop_lut(step_r);
    opa      = sel_opnd(uop.a, cos_r[0], sin_r[0], cos_r[1], sin_r[1], cos_r[2], sin_r[2],
                        ta_r, tb_r);
    opb      = sel_opnd(uop.b, cos_r[0], sin_r[0], cos_r[1], sin_r[1], cos_r[2], sin_r[2],
                        ta_r, tb_r);
    prod_nxt = opa * opb;
    prod_rnd = (prod_r + HALF_Q30) >>> 30;
    rnd      = prod_rnd[CW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (angle_wr) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = (resid_u == '0) ? ST_STORE : ST_ITER;
      ST_ITER:  if (iter_r == LAST_ITER) state_nxt = ST_STORE;
      ST_STORE: state_nxt = (axis_r == 2'd2) ? ST_MUL : ST_LOAD;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (step_r == LAST_STEP) ? ST_IDLE : ST_MUL;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      iter_r  <= '0;
      step_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        ang_r[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        mat_r[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
      end
    end else begin
      state_r <= state_nxt;
      if (angle_wr) begin
        case (cfg_index)
          REG_ANGLE_X: ang_r[0] <= cfg_angle;
          REG_ANGLE_Y: ang_r[1] <= cfg_angle;
          REG_ANGLE_Z: ang_r[2] <= cfg_angle;
          default: ;
        endcase
        axis_r <= '0;
      end
      case (state_r)
        ST_LOAD: begin
          iter_r <= '0;
        end
        ST_ITER: begin
          iter_r <= iter_r + 1'b1;
        end
        ST_STORE: begin
          axis_r <= axis_r + 1'b1;
          step_r <= '0;
        end
        ST_ACC: begin
          step_r <= step_r + 1'b1;
          case (uop.act)
            ACT_SET: mat_r[uop.dest] <= clamp_q30(40'(rnd));
            ACT_NEG: mat_r[uop.dest] <= clamp_q30(-40'(rnd));
            ACT_ADD: mat_r[uop.dest] <= clamp_q30(40'(acc_r) + 40'(rnd));
            ACT_SUB: mat_r[uop.dest] <= clamp_q30(40'(acc_r) - 40'(rnd));
            default: ;
          endcase
          if (step_r == LAST_STEP) begin
            mat_r[6] <= sin_r[1];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        quad_r <= quad;
        if (resid_u == '0) begin
          cx_r <= CW'(ONE_Q30);
        end else begin
          cx_r <= GAIN;
        end
        cy_r <= '0;
        cz_r <= CW'($signed(resid_u));
      end
      ST_ITER: begin
        if (!cz_r[CW-1]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + atan_v;
        end
      end
      ST_STORE: begin
        cos_r[axis_r] <= cos_v;
        sin_r[axis_r] <= sin_v;
      end
      ST_MUL: begin
        prod_r <= prod_nxt;
      end
      ST_ACC: begin
        case (uop.act)
          ACT_TA:  ta_r  <= rnd[COEF_WIDTH-1:0];
          ACT_TB:  tb_r  <= rnd[COEF_WIDTH-1:0];
          ACT_ACC: acc_r <= rnd;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

/* design/vst_front.sv */
module vst_front import vst_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           hold,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic signed [COORD_WIDTH-1:0]  in_x,
  input  logic signed [COORD_WIDTH-1:0]  in_y,
  input  logic signed [COORD_WIDTH-1:0]  in_z,
  input  logic signed [SCALE_WIDTH-1:0]  scale,
  input  logic signed [COORD_WIDTH-1:0]  offset_x,
  input  logic signed [COORD_WIDTH-1:0]  offset_y,
  input  logic signed [COORD_WIDTH-1:0]  offset_z,
  output logic                           q_push,
  output vec_t                           q_data,
  input  logic                           q_full
);

  localparam int XW = COORD_WIDTH + 1;
  localparam int PW = XW + SCALE_WIDTH;
  localparam logic signed [PW-1:0] HALF = 32768;

  logic                    valid_r;
  logic                    mode_r;
  logic signed [PW-1:0]    px_r;
  logic signed [PW-1:0]    py_r;
  logic signed [PW-1:0]    pz_r;
  logic signed [XW-1:0]    sx;
  logic signed [XW-1:0]    sy;
  logic signed [XW-1:0]    sz;
  logic signed [SCALE_WIDTH-1:0] sf;
  logic signed [PW-1:0]    rx;
  logic signed [PW-1:0]    ry;
  logic signed [PW-1:0]    rz;
  logic                    take;

  assign in_stall = hold || (valid_r && q_full);
  assign take     = in_valid && !in_stall;
  assign q_push   = valid_r && !q_full;

  // y is mirrored; direction items use a unit scale and no offset
  always_comb begin
    sx = XW'(in_x);
    sy = -XW'(in_y);
    sz = XW'(in_z);
    sf = in_mode ? SCALE_ONE : scale;
    rx = (px_r + HALF) >>> 16;
    ry = (py_r + HALF) >>> 16;
    rz = (pz_r + HALF) >>> 16;
    q_data.x = VEC_WIDTH'(rx) + (mode_r ? vcomp_t'(0) : VEC_WIDTH'(offset_x));
    q_data.y = VEC_WIDTH'(ry) + (mode_r ? vcomp_t'(0) : VEC_WIDTH'(offset_y));
    q_data.z = VEC_WIDTH'(rz) + (mode_r ? vcomp_t'(0) : VEC_WIDTH'(offset_z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      px_r   <= sx * sf;
      py_r   <= sy * sf;
      pz_r   <= sz * sf;
    end
  end

endmodule

/* design/vst_back.sv */
module vst_back import vst_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mat_t                           mat,
  input  vec_t                           q_data,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_WIDTH-1:0]  out_x,
  output logic signed [COORD_WIDTH-1:0]  out_y,
  output logic signed [COORD_WIDTH-1:0]  out_z,
  output logic                           out_saturated
);

  localparam int HPW = COEF_WIDTH + HI_WIDTH;
  localparam int LPW = COEF_WIDTH + LO_WIDTH + 1;
  localparam int SW  = COEF_WIDTH + VEC_WIDTH + 3;
  localparam logic signed [SW-1:0] RND  = 536870912;
  localparam logic signed [SW-1:0] MAXC =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINC =
    {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic                       en;
  logic                       b_valid_r;
  logic                       out_valid_r;
  logic signed [HPW-1:0]      phi_r [3][3];
  logic signed [LPW-1:0]      plo_r [3][3];
  logic signed [HPW-1:0]      phi_nxt [3][3];
  logic signed [LPW-1:0]      plo_nxt [3][3];
  vcomp_t                     v [3];
  logic signed [SW-1:0]       dot [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic [2:0]                 sat;
  logic signed [COORD_WIDTH-1:0] out_r [3];
  logic                       sat_r;

  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_x     = out_r[0];
  assign out_y     = out_r[1];
  assign out_z     = out_r[2];
  assign out_saturated = sat_r;

  // each product is split into a high and a low part of the vector component
  always_comb begin
    v[0] = q_data.x;
    v[1] = q_data.y;
    v[2] = q_data.z;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        phi_nxt[i][k] = mat[3*i+k] * $signed(v[k][VEC_WIDTH-1:LO_WIDTH]);
        plo_nxt[i][k] = mat[3*i+k] * $signed({1'b0, v[k][LO_WIDTH-1:0]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i] = (((SW'(phi_r[i][0]) + SW'(phi_r[i][1]) + SW'(phi_r[i][2])) <<< LO_WIDTH)
               + SW'(plo_r[i][0]) + SW'(plo_r[i][1]) + SW'(plo_r[i][2]) + RND) >>> 30;
      sat[i] = (dot[i] > MAXC) || (dot[i] < MINC);
      if (dot[i] > MAXC) begin
        res[i] = MAXC[COORD_WIDTH-1:0];
      end else if (dot[i] < MINC) begin
        res[i] = MINC[COORD_WIDTH-1:0];
      end else begin
        res[i] = dot[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r   <= q_pop;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      phi_r <= phi_nxt;
      plo_r <= plo_nxt;
    end
    if (en && b_valid_r) begin
      out_r <= res;
      sat_r <= |sat;
    end
  end

endmodule

/* design/vertex_scale_translate_rotate.sv */
// Vertex transform: one 3D point or direction per transaction, signed Q16.16 in and out.
// Input channel: in_valid/in_stall with in_mode (0 point, 1 direction), in_x, in_y, in_z.
// Points are scaled, mirrored in Y, translated and rotated; directions are mirrored and
// rotated. Result channel: out_valid/out_stall with out_x, out_y, out_z and out_saturated,
// which flags a component clamped to the Q16.16 range.
// Throughput is one transaction per cycle while no rebuild, full queue or receiver stall holds
// the input. From input acceptance to out_valid: the scale product is registered at
// acceptance, then come the queue write, the row product stage and the sum/saturate stage.
// A 4-entry queue sits between the scaling front end and the rotation back end.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, written while idle.
// A write to any angle register rebuilds the rotation matrix: one CORDIC per angle at one
// iteration a cycle, then fourteen shared multiplies, each in a multiply and an accumulate state.
// During the rebuild cfg_ready is low and in_stall is high.
// Reset clears all channels, loads unit scale, zero offsets, zero angles and the identity
// matrix. When the receiver stalls, the result holds; the pipeline and queue fill up and
// then in_stall rises.
module vertex_scale_translate_rotate import vst_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic signed [COORD_WIDTH-1:0]  in_x,
  input  logic signed [COORD_WIDTH-1:0]  in_y,
  input  logic signed [COORD_WIDTH-1:0]  in_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_WIDTH-1:0]  out_x,
  output logic signed [COORD_WIDTH-1:0]  out_y,
  output logic signed [COORD_WIDTH-1:0]  out_z,
  output logic                           out_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

  logic signed [SCALE_WIDTH-1:0]  scale_r;
  logic signed [COORD_WIDTH-1:0]  offset_x_r;
  logic signed [COORD_WIDTH-1:0]  offset_y_r;
  logic signed [COORD_WIDTH-1:0]  offset_z_r;
  logic                           cfg_we;
  logic                           busy;
  mat_t                           mat;
  logic                           q_push;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_empty;
  vec_t                           q_in;
  vec_t                           q_out;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= SCALE_ONE;
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:    scale_r    <= cfg_data[SCALE_WIDTH-1:0];
        REG_OFFSET_X: offset_x_r <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y: offset_y_r <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Z: offset_z_r <= cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  vst_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_angle (cfg_data[ANGLE_WIDTH-1:0]),
    .busy      (busy),
    .mat       (mat)
  );

  vst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (busy),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .scale    (scale_r),
    .offset_x (offset_x_r),
    .offset_y (offset_y_r),
    .offset_z (offset_z_r),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  vst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  vst_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mat           (mat),
    .q_data        (q_out),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

endmodule

/* tb/sv/vertex_scale_translate_rotate_tb.sv */
module vertex_scale_translate_rotate_tb;
  import vst_pkg::*;

  class vertex_scoreboard;
    typedef struct {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic                          sat;
    } vtx_result_t;

    longint scale;
    longint off_x;
    longint off_y;
    longint off_z;
    int unsigned ang [3];
    longint coef [9];
    longint atan_tab [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    vtx_result_t results_due [$];
    int errors;

    function new();
      scale = 65536;
      off_x = 0;
      off_y = 0;
      off_z = 0;
      foreach (ang[i]) ang[i] = 0;
      foreach (coef[i]) coef[i] = (i % 4 == 0) ? 64'sd1 <<< 30 : 0;
      errors = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function longint clamp_unit(longint v);
      longint one;
      one = 64'sd1 <<< 30;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
    endfunction

    function longint mul_q30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function void sin_cos(int unsigned angle, output longint c, output longint s);
      bit [31:0] phase;
      bit [31:0] biased;
      bit [31:0] quad;
      bit [31:0] ru;
      longint r, x, y, dx, dy;
      phase = {angle[ANGLE_WIDTH-1:0], 16'h0};
      biased = phase + 32'h2000_0000;
      quad = biased >> 30;
      ru = phase - (quad << 30);
      r = longint'(signed'(ru));
      x = 64'sd1 <<< 30;
      y = 0;
      if (r != 0) begin
        x = 652032874;
        for (int i = 0; i < 30; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (r >= 0) begin
            x -= dx; y += dy; r -= atan_tab[i];
          end else begin
            x += dx; y -= dy; r += atan_tab[i];
          end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
      end
      case (quad)
        0: begin c = x; s = y; end
        1: begin c = -y; s = x; end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void rebuild_matrix();
      longint c0, s0, c1, s1, c2, s2;
      sin_cos(ang[0], c0, s0);
      sin_cos(ang[1], c1, s1);
      sin_cos(ang[2], c2, s2);
      coef[0] = clamp_unit(mul_q30(c1, c2));
      coef[1] = clamp_unit(mul_q30(c0, s2) + mul_q30(mul_q30(s0, s1), c2));
      coef[2] = clamp_unit(mul_q30(s0, s2) - mul_q30(mul_q30(c0, s1), c2));
      coef[3] = clamp_unit(-mul_q30(c1, s2));
      coef[4] = clamp_unit(mul_q30(c0, c2) - mul_q30(mul_q30(s0, s1), s2));
      coef[5] = clamp_unit(mul_q30(s0, c2) + mul_q30(mul_q30(c0, s1), s2));
      coef[6] = clamp_unit(s1);
      coef[7] = clamp_unit(-mul_q30(s0, c1));
      coef[8] = clamp_unit(mul_q30(c0, c1));
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_SCALE:    scale = longint'(signed'(data[SCALE_WIDTH-1:0]));
        REG_OFFSET_X: off_x = longint'(signed'(data));
        REG_OFFSET_Y: off_y = longint'(signed'(data));
        REG_OFFSET_Z: off_z = longint'(signed'(data));
        REG_ANGLE_X: begin ang[0] = data[ANGLE_WIDTH-1:0]; rebuild_matrix(); end
        REG_ANGLE_Y: begin ang[1] = data[ANGLE_WIDTH-1:0]; rebuild_matrix(); end
        REG_ANGLE_Z: begin ang[2] = data[ANGLE_WIDTH-1:0]; rebuild_matrix(); end
        default: ;
      endcase
    endfunction

    function longint scale_component(longint v);
      longint hi, lo;
      hi = v >>> 16;
      lo = v - (hi <<< 16);
      return hi * scale + ((lo * scale + 32768) >>> 16);
    endfunction

    function longint rotate_row(int row, longint vec [3]);
      longint sh, sl, hi, lo;
      sh = 0;
      sl = 0;
      for (int k = 0; k < 3; k++) begin
        hi = vec[k] >>> 24;
        lo = vec[k] - (hi <<< 24);
        sh += coef[3*row+k] * hi;
        sl += coef[3*row+k] * lo;
      end
      return (sh + ((sl + (64'sd1 <<< 29)) >>> 24)) >>> 6;
    endfunction

    function void note_input(logic mode, logic signed [COORD_WIDTH-1:0] ix,
                             logic signed [COORD_WIDTH-1:0] iy,
                             logic signed [COORD_WIDTH-1:0] iz);
      longint vec [3];
      longint r [3];
      vtx_result_t res;
      vec[0] = longint'(ix);
      vec[1] = -longint'(iy);
      vec[2] = longint'(iz);
      if (mode == 1'b0) begin
        vec[0] = scale_component(vec[0]) + off_x;
        vec[1] = scale_component(vec[1]) + off_y;
        vec[2] = scale_component(vec[2]) + off_z;
      end
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        r[i] = rotate_row(i, vec);
        if (r[i] > 64'sd2147483647) begin r[i] = 64'sd2147483647; res.sat = 1'b1; end
        if (r[i] < -64'sd2147483648) begin r[i] = -64'sd2147483648; res.sat = 1'b1; end
      end
      res.x = r[0][COORD_WIDTH-1:0];
      res.y = r[1][COORD_WIDTH-1:0];
      res.z = r[2][COORD_WIDTH-1:0];
      results_due = {results_due, res};
    endfunction

    function void check_result(logic signed [COORD_WIDTH-1:0] ox,
                               logic signed [COORD_WIDTH-1:0] oy,
                               logic signed [COORD_WIDTH-1:0] oz, logic osat);
      vtx_result_t want;
      if (results_due.size() == 0) begin
        $error("result transaction with none outstanding: x %0d y %0d z %0d", ox, oy, oz);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (ox !== want.x) begin
        $error("out_x expected %0d actual %0d", want.x, ox); errors++;
      end
      if (oy !== want.y) begin
        $error("out_y expected %0d actual %0d", want.y, oy); errors++;
      end
      if (oz !== want.z) begin
        $error("out_z expected %0d actual %0d", want.z, oz); errors++;
      end
      if (osat !== want.sat) begin
        $error("out_saturated expected %0b actual %0b", want.sat, osat); errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_mode = 1'b0;
  logic signed [COORD_WIDTH-1:0] in_x = '0;
  logic signed [COORD_WIDTH-1:0] in_y = '0;
  logic signed [COORD_WIDTH-1:0] in_z = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          out_saturated;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]      cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data = '0;

  vertex_scoreboard vtx_board = new();
  int  cycle_count = 0;
  bit  sender_calm = 1'b0;

  vertex_scale_translate_rotate dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      vtx_board.check_result(out_x, out_y, out_z, out_saturated);
  end

  // receiver backpressure, with a quiet window in the middle of the run
  always @(negedge clk) begin
    if (cycle_count > 2500 && cycle_count < 4500)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < 38);
  end

  task automatic write_cfg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    vtx_board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (vtx_board.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic send_vertex(logic mode, logic signed [COORD_WIDTH-1:0] vx,
                             logic signed [COORD_WIDTH-1:0] vy,
                             logic signed [COORD_WIDTH-1:0] vz);
    @(negedge clk);
    while (!sender_calm && $urandom_range(0, 99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_x = vx;
    in_y = vy;
    in_z = vz;
    do @(posedge clk); while (in_stall);
    vtx_board.note_input(mode, vx, vy, vz);
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: return $urandom;
      default: return signed'($urandom) >>> $urandom_range(4, 20);
    endcase
  endfunction

  initial begin
    logic signed [COORD_WIDTH-1:0] edge_vals [6] =
      '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1, 32'sh0001_0000};
    int unsigned angle_picks [9] =
      '{0, 16'h2000, 16'h1FFF, 16'h4000, 16'h6000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // identity transform, extreme coordinates in both modes
    foreach (edge_vals[i]) begin
      send_vertex(1'b0, edge_vals[i], edge_vals[(i+1)%6], edge_vals[(i+2)%6]);
      send_vertex(1'b1, edge_vals[i], edge_vals[(i+3)%6], edge_vals[(i+5)%6]);
    end
    wait_drained();

    // extreme scale and offsets, unknown register index ignored
    write_cfg(REG_SCALE, 32'hFF80_0000);
    write_cfg(REG_OFFSET_X, 32'h7FFF_FFFF);
    write_cfg(REG_OFFSET_Y, 32'h8000_0000);
    write_cfg(REG_OFFSET_Z, 32'hFFFF_FFFF);
    write_cfg(3'd7, $urandom);
    write_cfg(REG_ANGLE_X, 32'h2000);
    write_cfg(REG_ANGLE_Y, 32'h4000);
    write_cfg(REG_ANGLE_Z, 32'hFFFF);
    foreach (edge_vals[i]) send_vertex(i[0], edge_vals[i], edge_vals[5-i], edge_vals[i]);
    send_vertex(1'b0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    wait_drained();
    write_cfg(REG_SCALE, 32'h007F_FFFF);
    send_vertex(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000);
    send_vertex(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_cfg(REG_SCALE, (phase == 0) ? 32'h0001_0000 : $urandom);
      write_cfg(REG_OFFSET_X, (phase < 2) ? 32'h0 : signed'($urandom) >>> $urandom_range(0, 16));
      write_cfg(REG_OFFSET_Y, signed'($urandom) >>> $urandom_range(0, 16));
      write_cfg(REG_OFFSET_Z, signed'($urandom) >>> $urandom_range(0, 16));
      write_cfg(REG_ANGLE_X, ($urandom_range(0, 1) != 0) ? angle_picks[$urandom_range(0, 8)]
                                                          : $urandom);
      write_cfg(REG_ANGLE_Y, ($urandom_range(0, 1) != 0) ? angle_picks[$urandom_range(0, 8)]
                                                          : $urandom);
      write_cfg(REG_ANGLE_Z, ($urandom_range(0, 1) != 0) ? angle_picks[$urandom_range(0, 8)]
                                                          : $urandom);
      sender_calm = (phase == 3);
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && phase[0]) begin
          // hold off until the pipeline has emptied
          @(negedge clk);
          in_valid = 1'b0;
          while (vtx_board.pending() != 0) @(negedge clk);
        end
        send_vertex($urandom_range(0, 1), pick_coord(), pick_coord(), pick_coord());
      end
      sender_calm = 1'b0;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (vtx_board.errors == 0 && vtx_board.pending() == 0)
      $display("vertex_scale_translate_rotate verification clean");
    else
      $display("vertex_scale_translate_rotate verification failed");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("vertex_scale_translate_rotate verification failed");
    $finish;
  end

endmodule
